// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the calcium release simulator RTL.
// Each macro expects i_clk and i_rst_n to exist in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define SCR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define SCR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/scr_pkg.sv -----
// Shared types, constants and the Hill threshold table builder for the release simulator.
// Used by scr_front, scr_back and the top level; depends on nothing.
package scr_pkg;

    localparam int POS_W      = 16;
    localparam int DUR_W      = 15;
    localparam int DRAW_W     = 16;
    localparam int OUT_TICK_W = 16;
    localparam int UIDX_W     = 5;
    localparam int THR_W      = 15;
    localparam int ROM_AW     = 9;
    localparam int ROM_DEPTH  = 512;
    localparam int ROM_MAX    = 511;

    localparam logic [1:0] REG_OPEN_DUR  = 2'd0;
    localparam logic [1:0] REG_INACT_DUR = 2'd1;
    localparam logic [1:0] REG_UPTAKE    = 2'd2;

    localparam logic [DUR_W-1:0]  OPEN_DUR_RST  = 15'd50;
    localparam logic [DUR_W-1:0]  INACT_DUR_RST = 15'd200;
    localparam logic [DRAW_W-1:0] UPTAKE_RST    = 16'd655;
    localparam int                UNIT0_STAMP   = 25;

    localparam int          HILL_HALF = 100;
    localparam int          HILL_EXP  = 10;
    localparam int          PMIN_Q    = 7;
    localparam int          PMAX_Q    = 19661;
    localparam logic [63:0] Q31_ONE   = 64'd1 << 31;

    typedef enum logic [1:0] {
        US_CLOSED   = 2'd0,
        US_OPEN     = 2'd1,
        US_INACTIVE = 2'd2
    } t_unit_state;

    typedef struct packed {
        logic [DUR_W-1:0]  open_duration;
        logic [DUR_W-1:0]  inactive_duration;
        logic [DRAW_W-1:0] uptake_threshold;
    } t_cfg;

    typedef struct packed {
        logic                     is_ion;
        logic [UIDX_W-1:0]        unit_index;
        logic                     unit_ok;
        logic [DRAW_W-1:0]        open_draw;
        logic signed [POS_W-1:0]  new_pos;
        logic                     in_cyto;
        logic                     uptake_hit;
        logic                     last;
    } t_req;

    typedef struct packed {
        logic signed [7:0]       new_position;
        logic                    now_in_cytosol;
        logic                    was_released;
        logic                    was_taken_up;
        t_unit_state             unit_state;
        logic [OUT_TICK_W-1:0]   tick_now;
    } t_res;

    typedef logic [THR_W-1:0] t_hill_rom [ROM_DEPTH];

    // Restoring long division, evaluated only while the table is elaborated.
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], num[i]};
            if (r >= den) begin
                r = r - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [THR_W-1:0] hill_threshold(input int unsigned n);
        logic [63:0] x;
        logic [63:0] p;
        logic [63:0] h;
        logic [63:0] t;
        if (n == 0) begin
            return THR_W'(PMIN_Q);
        end
        if (n < HILL_HALF) begin
            x = (64'(n) << 31) / HILL_HALF;
        end else begin
            x = div64(64'(HILL_HALF) << 31, 64'(n));
        end
        p = x;
        for (int i = 1; i < HILL_EXP; i++) begin
            p = (p * x) >> 31;
        end
        if (n < HILL_HALF) begin
            h = div64(p << 31, Q31_ONE + p);
        end else begin
            h = div64(Q31_ONE << 31, Q31_ONE + p);
        end
        t = (64'(PMAX_Q) * h + (Q31_ONE >> 1)) >> 31;
        return THR_W'(64'(PMIN_Q) + t);
    endfunction

    // Counts at or above the last entry all give the saturated threshold.
    function automatic t_hill_rom hill_rom_build();
        t_hill_rom rom;
        for (int n = 0; n < ROM_DEPTH; n++) begin
            rom[n] = hill_threshold(n);
        end
        return rom;
    endfunction

endpackage

// ----- rtl/scr_fifo.sv -----
// Small show-ahead queue used between the front and back parts and on the result side.
// Generic in its payload type; no package dependency.
module scr_fifo #(
    parameter type t_data = logic,
    parameter int  DEPTH  = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_rd,
    output t_data o_data,
    output logic  o_empty
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    t_data           r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;
    logic            wr_en;
    logic            rd_en;

    always_comb begin
        o_full   = r_count == CNTW'(DEPTH);
        o_empty  = r_count == '0;
        o_data   = r_mem[r_rd_ptr];
        wr_en    = i_wr && !o_full;
        rd_en    = i_rd && !o_empty;
        n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/scr_front.sv -----
// Front part: classifies an input beat and does the state-free ion step arithmetic.
// Depends on scr_pkg for the request and configuration types.
module scr_front #(
    parameter int HALF_RANGE = 100,
    parameter int UNIT_COUNT = 21
) (
    input  logic                            i_req_type,
    input  logic [scr_pkg::UIDX_W-1:0]      i_unit_index,
    input  logic [scr_pkg::DRAW_W-1:0]      i_open_draw,
    input  logic signed [7:0]               i_ion_position,
    input  logic                            i_ion_in_cytosol,
    input  logic                            i_step_up,
    input  logic [scr_pkg::DRAW_W-1:0]      i_uptake_draw,
    input  logic                            i_last_of_tick,
    input  logic [scr_pkg::DRAW_W-1:0]      i_uptake_threshold,
    output scr_pkg::t_req                   o_req
);

    localparam int FW = $clog2(2 * HALF_RANGE + 130) + 1;
    localparam int PW = scr_pkg::POS_W;
    localparam logic signed [FW-1:0] HR  = FW'(HALF_RANGE);
    localparam logic signed [FW-1:0] HR2 = FW'(2 * HALF_RANGE);

    logic signed [FW-1:0] pos_x;
    logic signed [FW-1:0] step;
    logic signed [FW-1:0] stepped;
    logic signed [FW-1:0] refl;
    logic signed [FW-1:0] clamped;
    logic [6:0]           unit_x;

    always_comb begin
        pos_x   = FW'(i_ion_position);
        step    = {{(FW - 1){~i_step_up}}, 1'b1};
        stepped = pos_x + step;
        if (stepped < -HR) begin
            refl = -HR2 - stepped;
        end else if (stepped > HR) begin
            refl = HR2 - stepped;
        end else begin
            refl = stepped;
        end
        if (refl < -HR) begin
            clamped = -HR;
        end else if (refl > HR) begin
            clamped = HR;
        end else begin
            clamped = refl;
        end
        unit_x = {2'b00, i_unit_index};

        o_req.is_ion     = i_req_type;
        o_req.unit_index = i_unit_index;
        o_req.unit_ok    = unit_x < 7'(UNIT_COUNT);
        o_req.open_draw  = i_open_draw;
        o_req.new_pos    = PW'(clamped);
        o_req.in_cyto    = i_ion_in_cytosol;
        o_req.uptake_hit = i_uptake_draw < i_uptake_threshold;
        o_req.last       = i_last_of_tick;
    end

endmodule

// ----- rtl/scr_back.sv -----
// Back part: holds the release unit table, window counts and tick, and executes requests.
// Depends on scr_pkg for types and the Hill threshold table builder.
module scr_back #(
    parameter int HALF_RANGE   = 100,
    parameter int UNIT_SPACING = 10,
    parameter int UNIT_COUNT   = 21,
    parameter int COUNT_BITS   = 10,
    parameter int TICK_BITS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scr_pkg::t_cfg i_cfg,
    input  scr_pkg::t_req i_req,
    input  logic          i_req_empty,
    output logic          o_req_pop,
    input  logic          i_res_full,
    output logic          o_res_wr,
    output scr_pkg::t_res o_res
);

    localparam int UI_W = $clog2(UNIT_COUNT);
    localparam int SW   = $clog2(HALF_RANGE + UNIT_SPACING * (UNIT_COUNT + 1) + 1) + 2;
    localparam int CW   = (SW > scr_pkg::POS_W) ? SW : scr_pkg::POS_W;
    localparam int DW   = (TICK_BITS > scr_pkg::DUR_W) ? TICK_BITS : scr_pkg::DUR_W;
    localparam int AW   = scr_pkg::ROM_AW;
    localparam int NXW  = COUNT_BITS + AW;
    localparam int OTW  = scr_pkg::OUT_TICK_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam scr_pkg::t_hill_rom HILL_ROM = scr_pkg::hill_rom_build();

    typedef enum logic {
        PH_RUN,
        PH_UNIT
    } t_phase;

    t_phase                          r_phase;
    scr_pkg::t_unit_state            r_unit_state [UNIT_COUNT];
    logic [TICK_BITS-1:0]            r_unit_stamp [UNIT_COUNT];
    logic [COUNT_BITS-1:0]           r_window     [UNIT_COUNT];
    logic [TICK_BITS-1:0]            r_tick;
    logic [UI_W-1:0]                 r_u;
    logic [scr_pkg::DRAW_W-1:0]      r_draw;
    logic [scr_pkg::THR_W-1:0]       r_thr;

    logic [UI_W+4:0]                 u_ext;
    logic [UI_W-1:0]                 head_u;
    logic [NXW-1:0]                  n_ext;
    logic [AW-1:0]                   rom_addr;
    logic signed [CW-1:0]            pos_c;
    logic [UNIT_COUNT-1:0]           site_open;
    logic [UNIT_COUNT-1:0]           in_win;
    logic                            rel;
    logic                            cyto_mid;
    logic                            up;
    logic                            cyto_fin;
    scr_pkg::t_unit_state            cur_state;
    scr_pkg::t_unit_state            next_state;
    logic                            stamp_upd;
    logic [TICK_BITS-1:0]            wait_d;
    logic [DW-1:0]                   wait_x;
    logic                            open_done;
    logic                            inact_done;
    logic                            go;
    logic                            ion_go;
    logic                            unit_go;
    logic                            bad_go;
    logic                            unit_fin;
    logic [TICK_BITS+OTW-1:0]        tick_ext;

    for (genvar g = 0; g < UNIT_COUNT; g++) begin : g_site
        localparam logic signed [CW-1:0] SITE = CW'(UNIT_SPACING * g - HALF_RANGE);
        localparam logic signed [CW-1:0] LO   = CW'(UNIT_SPACING * (g - 1) - HALF_RANGE);
        localparam logic signed [CW-1:0] HI   = CW'(UNIT_SPACING * (g + 1) - HALF_RANGE);
        assign site_open[g] = (pos_c == SITE) && (r_unit_state[g] == scr_pkg::US_OPEN);
        assign in_win[g]    = (pos_c > LO) && (pos_c < HI);
    end

    always_comb begin
        u_ext    = {{UI_W{1'b0}}, i_req.unit_index};
        head_u   = u_ext[UI_W-1:0];
        n_ext    = {{AW{1'b0}}, r_window[head_u]};
        rom_addr = (n_ext > NXW'(scr_pkg::ROM_MAX)) ? AW'(scr_pkg::ROM_MAX) : n_ext[AW-1:0];

        pos_c    = CW'(i_req.new_pos);
        rel      = !i_req.in_cyto && (|site_open);
        cyto_mid = i_req.in_cyto || rel;
        up       = cyto_mid && i_req.uptake_hit;
        cyto_fin = cyto_mid && !up;

        cur_state  = r_unit_state[r_u];
        wait_d     = r_tick - r_unit_stamp[r_u];
        wait_x     = DW'(wait_d);
        open_done  = !wait_d[TICK_BITS-1] && (wait_x >= DW'(i_cfg.open_duration));
        inact_done = !wait_d[TICK_BITS-1] && (wait_x >= DW'(i_cfg.inactive_duration));
        next_state = cur_state;
        stamp_upd  = 1'b0;
        case (cur_state)
            scr_pkg::US_CLOSED: begin
                if (r_draw < {1'b0, r_thr}) begin
                    next_state = scr_pkg::US_OPEN;
                    stamp_upd  = 1'b1;
                end
            end
            scr_pkg::US_OPEN: begin
                if (open_done) begin
                    next_state = scr_pkg::US_INACTIVE;
                    stamp_upd  = 1'b1;
                end
            end
            scr_pkg::US_INACTIVE: begin
                if (inact_done) begin
                    next_state = scr_pkg::US_CLOSED;
                end
            end
            default: begin
                next_state = cur_state;
            end
        endcase

        go        = (r_phase == PH_RUN) && !i_req_empty && !i_res_full;
        ion_go    = go && i_req.is_ion;
        unit_go   = go && !i_req.is_ion && i_req.unit_ok;
        bad_go    = go && !i_req.is_ion && !i_req.unit_ok;
        unit_fin  = r_phase == PH_UNIT;
        o_req_pop = go;
        o_res_wr  = ion_go || bad_go || unit_fin;

        tick_ext             = {{OTW{1'b0}}, r_tick};
        o_res.new_position   = '0;
        o_res.now_in_cytosol = 1'b0;
        o_res.was_released   = 1'b0;
        o_res.was_taken_up   = 1'b0;
        o_res.unit_state     = scr_pkg::US_CLOSED;
        o_res.tick_now       = tick_ext[OTW-1:0];
        if (unit_fin) begin
            o_res.unit_state = next_state;
        end else if (ion_go) begin
            o_res.new_position   = i_req.new_pos[7:0];
            o_res.now_in_cytosol = cyto_fin;
            o_res.was_released   = rel;
            o_res.was_taken_up   = up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RUN;
            r_tick  <= '0;
            for (int j = 0; j < UNIT_COUNT; j++) begin
                r_unit_state[j] <= (j == 0) ? scr_pkg::US_OPEN : scr_pkg::US_CLOSED;
                r_unit_stamp[j] <= (j == 0) ? TICK_BITS'(scr_pkg::UNIT0_STAMP) : '0;
                r_window[j]     <= '0;
            end
        end else begin
            case (r_phase)
                PH_RUN: begin
                    if (unit_go) begin
                        r_phase <= PH_UNIT;
                    end
                end
                PH_UNIT: begin
                    r_phase <= PH_RUN;
                end
                default: begin
                    r_phase <= PH_RUN;
                end
            endcase
            if (unit_go) begin
                r_u    <= head_u;
                r_draw <= i_req.open_draw;
                r_thr  <= HILL_ROM[rom_addr];
            end
            if (unit_fin) begin
                r_unit_state[r_u] <= next_state;
                if (stamp_upd) begin
                    r_unit_stamp[r_u] <= r_tick;
                end
            end
            for (int j = 0; j < UNIT_COUNT; j++) begin
                if (unit_go && (head_u == UI_W'(j))) begin
                    r_window[j] <= '0;
                end else if (ion_go && cyto_fin && in_win[j] && (r_window[j] != COUNT_MAX)) begin
                    r_window[j] <= r_window[j] + 1'b1;
                end
            end
            if (ion_go && i_req.last) begin
                r_tick <= r_tick + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/stochastic_calcium_release_sim.sv -----
// Stochastic calcium release simulator: ion step items are executed from the request
// queue head, so a stream of them runs at one beat per clock while the result queue has
// room; a unit update with a valid index holds the flow in PH_UNIT, using the threshold
// registered from the Hill threshold ROM indexed by the unit's window count. Requests and
// results sit in small queues, so input and output stall independently. Registers:
// open_duration at 0x0, inactive_duration at 0x4, uptake_threshold at 0x8. No clearing pass
// follows reset. Depends on scr_pkg, scr_fifo, scr_front, scr_back and assert_macros.svh.
`include "assert_macros.svh"

module stochastic_calcium_release_sim #(
    parameter int HALF_RANGE   = 100,
    parameter int UNIT_SPACING = 10,
    parameter int UNIT_COUNT   = 21,
    parameter int COUNT_BITS   = 10,
    parameter int TICK_BITS    = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_req_type,
    input  logic [4:0]         i_unit_index,
    input  logic [15:0]        i_open_draw,
    input  logic signed [7:0]  i_ion_position,
    input  logic               i_ion_in_cytosol,
    input  logic               i_step_up,
    input  logic [15:0]        i_uptake_draw,
    input  logic               i_last_of_tick,
    output logic               empty,
    input  logic               pop,
    output logic signed [7:0]  o_new_position,
    output logic               o_now_in_cytosol,
    output logic               o_was_released,
    output logic               o_was_taken_up,
    output logic [1:0]         o_unit_state_out,
    output logic [15:0]        o_tick_now,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    scr_pkg::t_cfg r_cfg;
    scr_pkg::t_req front_req;
    scr_pkg::t_req q_head;
    scr_pkg::t_res back_res;
    scr_pkg::t_res res_head;
    logic          q_empty;
    logic          q_pop;
    logic          res_full;
    logic          res_wr;
    logic          cfg_wr;
    logic          cfg_open_wr;
    logic [1:0]    cfg_idx;

    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign cfg_idx     = paddr[3:2];
    assign cfg_open_wr = cfg_wr && (cfg_idx == scr_pkg::REG_OPEN_DUR);

    always_comb begin
        case (cfg_idx)
            scr_pkg::REG_OPEN_DUR:  prdata = {17'b0, r_cfg.open_duration};
            scr_pkg::REG_INACT_DUR: prdata = {17'b0, r_cfg.inactive_duration};
            scr_pkg::REG_UPTAKE:    prdata = {16'b0, r_cfg.uptake_threshold};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_duration     <= scr_pkg::OPEN_DUR_RST;
            r_cfg.inactive_duration <= scr_pkg::INACT_DUR_RST;
            r_cfg.uptake_threshold  <= scr_pkg::UPTAKE_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                scr_pkg::REG_OPEN_DUR:  r_cfg.open_duration     <= pwdata[14:0];
                scr_pkg::REG_INACT_DUR: r_cfg.inactive_duration <= pwdata[14:0];
                scr_pkg::REG_UPTAKE:    r_cfg.uptake_threshold  <= pwdata[15:0];
                default:                r_cfg <= r_cfg;
            endcase
        end
    end

    scr_front #(
        .HALF_RANGE (HALF_RANGE),
        .UNIT_COUNT (UNIT_COUNT)
    ) u_front (
        .i_req_type         (i_req_type),
        .i_unit_index       (i_unit_index),
        .i_open_draw        (i_open_draw),
        .i_ion_position     (i_ion_position),
        .i_ion_in_cytosol   (i_ion_in_cytosol),
        .i_step_up          (i_step_up),
        .i_uptake_draw      (i_uptake_draw),
        .i_last_of_tick     (i_last_of_tick),
        .i_uptake_threshold (r_cfg.uptake_threshold),
        .o_req              (front_req)
    );

    scr_fifo #(
        .t_data (scr_pkg::t_req),
        .DEPTH  (4)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_data  (front_req),
        .o_full  (full),
        .i_rd    (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    scr_back #(
        .HALF_RANGE   (HALF_RANGE),
        .UNIT_SPACING (UNIT_SPACING),
        .UNIT_COUNT   (UNIT_COUNT),
        .COUNT_BITS   (COUNT_BITS),
        .TICK_BITS    (TICK_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (q_head),
        .i_req_empty (q_empty),
        .o_req_pop   (q_pop),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res       (back_res)
    );

    scr_fifo #(
        .t_data (scr_pkg::t_res),
        .DEPTH  (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_new_position   = res_head.new_position;
    assign o_now_in_cytosol = res_head.now_in_cytosol;
    assign o_was_released   = res_head.was_released;
    assign o_was_taken_up   = res_head.was_taken_up;
    assign o_unit_state_out = res_head.unit_state;
    assign o_tick_now       = res_head.tick_now;

    `SCR_ASSERT_IMP(a_res_room, res_wr, !res_full)
    `SCR_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty)
    `SCR_ASSERT_NXT(a_unit_two_cycles, q_pop && !q_head.is_ion && q_head.unit_ok, !q_pop)
    `SCR_ASSERT_NXT(a_cfg_open, cfg_open_wr, r_cfg.open_duration == $past(pwdata[14:0]))

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for stochastic_calcium_release_sim: directed cases, window
// saturation under output back-pressure, and random ticks across register settings.
// Depends on scr_pkg and the RTL of the block; predicts every result beat internally.
module testbench;

    localparam int HALF_RANGE     = 100;
    localparam int UNIT_SPACING   = 10;
    localparam int UNIT_COUNT     = 21;
    localparam int COUNT_BITS     = 10;
    localparam int TICK_BITS      = 16;
    localparam int COUNT_MAX      = (1 << COUNT_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 130;

    typedef enum logic {
        REQ_UNIT = 1'b0,
        REQ_ION  = 1'b1
    } t_req_kind;

    typedef struct packed {
        t_req_kind         req_type;
        logic [4:0]        unit_index;
        logic [15:0]       open_draw;
        logic signed [7:0] ion_position;
        logic              ion_in_cytosol;
        logic              step_up;
        logic [15:0]       uptake_draw;
        logic              last_of_tick;
    } t_sim_request;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic              i_req_type = 1'b0;
    logic [4:0]        i_unit_index = '0;
    logic [15:0]       i_open_draw = '0;
    logic signed [7:0] i_ion_position = '0;
    logic              i_ion_in_cytosol = 1'b0;
    logic              i_step_up = 1'b0;
    logic [15:0]       i_uptake_draw = '0;
    logic              i_last_of_tick = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic signed [7:0] o_new_position;
    logic              o_now_in_cytosol;
    logic              o_was_released;
    logic              o_was_taken_up;
    logic [1:0]        o_unit_state_out;
    logic [15:0]       o_tick_now;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    scr_pkg::t_unit_state unit_state_m [UNIT_COUNT];
    logic [15:0]          unit_stamp_m [UNIT_COUNT];
    logic [9:0]           window_count_m [UNIT_COUNT];
    logic [15:0]          tick_count_m;
    logic [14:0]          cfg_open_dur;
    logic [14:0]          cfg_inact_dur;
    logic [15:0]          cfg_uptake;

    scr_pkg::t_res     awaited_outcomes [$];
    int                error_count = 0;
    int                sent_items = 0;
    int                stall_cycles = 0;
    int                hold_off_cycles = 0;
    bit                tx_idle = 1'b1;
    bit                rx_idle = 1'b1;

    stochastic_calcium_release_sim #(
        .HALF_RANGE(HALF_RANGE),
        .UNIT_SPACING(UNIT_SPACING),
        .UNIT_COUNT(UNIT_COUNT),
        .COUNT_BITS(COUNT_BITS),
        .TICK_BITS(TICK_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .push(push),
        .full(full),
        .i_req_type(i_req_type),
        .i_unit_index(i_unit_index),
        .i_open_draw(i_open_draw),
        .i_ion_position(i_ion_position),
        .i_ion_in_cytosol(i_ion_in_cytosol),
        .i_step_up(i_step_up),
        .i_uptake_draw(i_uptake_draw),
        .i_last_of_tick(i_last_of_tick),
        .empty(empty),
        .pop(pop),
        .o_new_position(o_new_position),
        .o_now_in_cytosol(o_now_in_cytosol),
        .o_was_released(o_was_released),
        .o_was_taken_up(o_was_taken_up),
        .o_unit_state_out(o_unit_state_out),
        .o_tick_now(o_tick_now),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic logic [15:0] hill_level(input int unsigned n);
        logic [63:0] x;
        logic [63:0] p;
        logic [63:0] h;
        logic [63:0] t;
        if (n == 0) begin
            return 16'(scr_pkg::PMIN_Q);
        end
        if (n < scr_pkg::HILL_HALF) begin
            x = (64'(n) << 31) / 64'(scr_pkg::HILL_HALF);
        end else begin
            x = (64'(scr_pkg::HILL_HALF) << 31) / 64'(n);
        end
        p = x;
        repeat (scr_pkg::HILL_EXP - 1) p = (p * x) >> 31;
        if (n < scr_pkg::HILL_HALF) begin
            h = (p << 31) / (scr_pkg::Q31_ONE + p);
        end else begin
            h = (scr_pkg::Q31_ONE << 31) / (scr_pkg::Q31_ONE + p);
        end
        t = (64'(scr_pkg::PMAX_Q) * h + (scr_pkg::Q31_ONE >> 1)) >> 31;
        return 16'(64'(scr_pkg::PMIN_Q) + t);
    endfunction

    function automatic scr_pkg::t_res next_release_outcome(input t_sim_request rq);
        scr_pkg::t_res res;
        int          pos;
        int          off;
        int          site;
        int          j;
        logic        cyto;
        logic [9:0]  n;
        logic [15:0] elapsed;
        res = '0;
        res.tick_now = tick_count_m;
        if (rq.req_type == REQ_UNIT) begin
            if (rq.unit_index < UNIT_COUNT) begin
                n = window_count_m[rq.unit_index];
                window_count_m[rq.unit_index] = '0;
                elapsed = tick_count_m - unit_stamp_m[rq.unit_index];
                case (unit_state_m[rq.unit_index])
                    scr_pkg::US_CLOSED: begin
                        if (rq.open_draw < hill_level(n)) begin
                            unit_state_m[rq.unit_index] = scr_pkg::US_OPEN;
                            unit_stamp_m[rq.unit_index] = tick_count_m;
                        end
                    end
                    scr_pkg::US_OPEN: begin
                        if (!elapsed[15] && elapsed >= {1'b0, cfg_open_dur}) begin
                            unit_state_m[rq.unit_index] = scr_pkg::US_INACTIVE;
                            unit_stamp_m[rq.unit_index] = tick_count_m;
                        end
                    end
                    default: begin
                        if (!elapsed[15] && elapsed >= {1'b0, cfg_inact_dur}) begin
                            unit_state_m[rq.unit_index] = scr_pkg::US_CLOSED;
                        end
                    end
                endcase
                res.unit_state = unit_state_m[rq.unit_index];
            end
        end else begin
            pos = $signed(rq.ion_position);
            pos = pos + (rq.step_up ? 1 : -1);
            if (pos < -HALF_RANGE) begin
                pos = -2 * HALF_RANGE - pos;
            end else if (pos > HALF_RANGE) begin
                pos = 2 * HALF_RANGE - pos;
            end
            if (pos < -HALF_RANGE) pos = -HALF_RANGE;
            if (pos > HALF_RANGE) pos = HALF_RANGE;
            cyto = rq.ion_in_cytosol;
            if (!cyto) begin
                off = pos + HALF_RANGE;
                if (off >= 0 && off % UNIT_SPACING == 0 && off / UNIT_SPACING < UNIT_COUNT) begin
                    if (unit_state_m[off / UNIT_SPACING] == scr_pkg::US_OPEN) begin
                        cyto = 1'b1;
                        res.was_released = 1'b1;
                    end
                end
            end
            if (cyto && rq.uptake_draw < cfg_uptake) begin
                cyto = 1'b0;
                res.was_taken_up = 1'b1;
            end
            if (cyto) begin
                for (j = 0; j < UNIT_COUNT; j++) begin
                    site = -HALF_RANGE + UNIT_SPACING * j;
                    if (pos > site - UNIT_SPACING && pos < site + UNIT_SPACING &&
                        window_count_m[j] < COUNT_MAX) begin
                        window_count_m[j] = window_count_m[j] + 1'b1;
                    end
                end
            end
            res.new_position = 8'(pos);
            res.now_in_cytosol = cyto;
            if (rq.last_of_tick) tick_count_m = tick_count_m + 1'b1;
        end
        return res;
    endfunction

    function automatic t_sim_request random_request();
        logic [63:0] raw_bits;
        raw_bits = {$urandom, $urandom};
        return t_sim_request'(raw_bits[$bits(t_sim_request)-1:0]);
    endfunction

    function automatic t_sim_request unit_req(input int idx, input logic [15:0] draw);
        t_sim_request r;
        r = random_request();
        r.req_type = REQ_UNIT;
        r.unit_index = 5'(idx);
        r.open_draw = draw;
        return r;
    endfunction

    function automatic t_sim_request ion_req(input int pos, input bit cyto, input bit up,
                                             input logic [15:0] udraw, input bit last);
        t_sim_request r;
        r = random_request();
        r.req_type = REQ_ION;
        r.ion_position = 8'(pos);
        r.ion_in_cytosol = cyto;
        r.step_up = up;
        r.uptake_draw = udraw;
        r.last_of_tick = last;
        return r;
    endfunction

    task automatic send_item(input t_sim_request rq);
        int gap;
        gap = tx_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_type <= rq.req_type;
        i_unit_index <= rq.unit_index;
        i_open_draw <= rq.open_draw;
        i_ion_position <= rq.ion_position;
        i_ion_in_cytosol <= rq.ion_in_cytosol;
        i_step_up <= rq.step_up;
        i_uptake_draw <= rq.uptake_draw;
        i_last_of_tick <= rq.last_of_tick;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        awaited_outcomes.push_back(next_release_outcome(rq));
        sent_items++;
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        logic [31:0] readback;
        case (idx)
            scr_pkg::REG_OPEN_DUR: begin
                cfg_open_dur = value[14:0];
                stored = {17'b0, value[14:0]};
            end
            scr_pkg::REG_INACT_DUR: begin
                cfg_inact_dur = value[14:0];
                stored = {17'b0, value[14:0]};
            end
            default: begin
                cfg_uptake = value[15:0];
                stored = {16'b0, value[15:0]};
            end
        endcase
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (readback !== stored) begin
            report_mismatch($sformatf("register %0d reads %0h, written %0h", idx, readback,
                                      stored));
        end
    endtask

    task automatic compare_outcome();
        scr_pkg::t_res want;
        if (awaited_outcomes.size() == 0) begin
            report_mismatch("result beat with no outstanding request");
            return;
        end
        want = awaited_outcomes.pop_front();
        if (o_new_position !== want.new_position)
            report_mismatch($sformatf("tick %0d new_position got %0d want %0d", want.tick_now,
                                      o_new_position, want.new_position));
        if (o_now_in_cytosol !== want.now_in_cytosol)
            report_mismatch($sformatf("tick %0d now_in_cytosol got %0b want %0b",
                                      want.tick_now, o_now_in_cytosol, want.now_in_cytosol));
        if (o_was_released !== want.was_released)
            report_mismatch($sformatf("tick %0d was_released got %0b want %0b", want.tick_now,
                                      o_was_released, want.was_released));
        if (o_was_taken_up !== want.was_taken_up)
            report_mismatch($sformatf("tick %0d was_taken_up got %0b want %0b", want.tick_now,
                                      o_was_taken_up, want.was_taken_up));
        if (o_unit_state_out !== want.unit_state)
            report_mismatch($sformatf("tick %0d unit_state_out got %0d want %0d",
                                      want.tick_now, o_unit_state_out, want.unit_state));
        if (o_tick_now !== want.tick_now)
            report_mismatch($sformatf("tick_now got %0d want %0d", o_tick_now, want.tick_now));
    endtask

    initial begin : result_drain
        int pause;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_cycles > 0) begin
                pause = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                pause = rx_idle ? $urandom_range(0, 10) : 0;
            end
            if (pause > 0) begin
                pop <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            compare_outcome();
            if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
        end
    end

    task automatic test_directed_cases();
        send_item(unit_req(0, 16'hFFFF));
        send_item(unit_req(21, 16'h0000));
        send_item(unit_req(31, 16'hFFFF));
        send_item(unit_req(1, 16'd7));
        send_item(unit_req(1, 16'd6));
        send_item(ion_req(-99, 1'b0, 1'b0, 16'hFFFF, 1'b0));
        send_item(ion_req(-100, 1'b0, 1'b0, 16'hFFFF, 1'b0));
        send_item(ion_req(100, 1'b1, 1'b1, 16'h0000, 1'b0));
        send_item(ion_req(127, 1'b1, 1'b1, 16'hFFFF, 1'b0));
        send_item(ion_req(-128, 1'b1, 1'b0, 16'hFFFF, 1'b0));
        send_item(ion_req(-91, 1'b0, 1'b1, 16'h0000, 1'b0));
        send_item(ion_req(-90, 1'b1, 1'b1, 16'hFFFF, 1'b0));
        send_item(ion_req(0, 1'b1, 1'b0, 16'hFFFF, 1'b1));
        send_item(unit_req(1, 16'hFFFF));
        send_item(unit_req(2, 16'h0000));
        send_item(unit_req(20, 16'hFFFF));
        send_item(ion_req(100, 1'b0, 1'b0, 16'hFFFF, 1'b0));
        send_item(ion_req(99, 1'b0, 1'b1, 16'hFFFF, 1'b0));
        send_item(ion_req(-1, 1'b0, 1'b1, 16'hFFFF, 1'b1));
        wait_idle();
        write_register(scr_pkg::REG_OPEN_DUR, 32'd0);
        write_register(scr_pkg::REG_INACT_DUR, 32'd1);
        send_item(unit_req(1, 16'hFFFF));
        send_item(unit_req(1, 16'hFFFF));
        send_item(ion_req(50, 1'b1, 1'b0, 16'hFFFF, 1'b1));
        send_item(unit_req(1, 16'hFFFF));
        wait_idle();
    endtask

    // The receiver stalls for a long stretch while cytosol ions pile into one window.
    task automatic test_window_saturation();
        write_register(scr_pkg::REG_UPTAKE, 32'd0);
        tx_idle = 1'b0;
        hold_off_cycles = 300;
        repeat (1040) begin
            send_item(ion_req(int'($urandom_range(0, 16)) - 8, 1'b1, 1'($urandom_range(0, 1)),
                              16'($urandom), 1'b0));
        end
        send_item(unit_req(10, 16'd19667));
        send_item(unit_req(9, 16'($urandom)));
        send_item(unit_req(11, 16'($urandom_range(0, 20000))));
        tx_idle = 1'b1;
        wait_idle();
    endtask

    task automatic run_random_tick();
        int n_units;
        int n_ions;
        int k;
        int pos;
        bit up;
        bit cyto;
        logic [15:0] draw;
        n_units = $urandom_range(0, 6);
        n_ions = $urandom_range(0, 10);
        if ($urandom_range(0, 19) == 0) tx_idle = !tx_idle;
        for (k = 0; k < n_units; k++) begin
            case ($urandom_range(0, 3))
                0: draw = 16'($urandom_range(0, 15));
                1: draw = 16'($urandom_range(0, 2000));
                default: draw = 16'($urandom);
            endcase
            send_item(unit_req(($urandom_range(0, 9) == 0) ? $urandom_range(21, 31)
                                                           : $urandom_range(0, 20), draw));
        end
        for (k = 0; k < n_ions; k++) begin
            up = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 9) < 4) begin
                pos = -HALF_RANGE + UNIT_SPACING * int'($urandom_range(0, 20)) + (up ? -1 : 1);
                cyto = ($urandom_range(0, 3) == 0);
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    pos = $signed(8'($urandom));
                end else begin
                    pos = int'($urandom_range(0, 200)) - HALF_RANGE;
                end
                cyto = 1'($urandom_range(0, 1));
            end
            draw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 1500)) : 16'($urandom);
            send_item(ion_req(pos, cyto, up, draw, k == n_ions - 1));
        end
        if ($urandom_range(0, 9) == 0) send_item(random_request());
    endtask

    task automatic test_random_ticks();
        int phase;
        int target;
        for (phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_register(scr_pkg::REG_OPEN_DUR, 32'd3);
                    write_register(scr_pkg::REG_INACT_DUR, 32'd8);
                    write_register(scr_pkg::REG_UPTAKE, 32'd655);
                end
                1: begin
                    write_register(scr_pkg::REG_OPEN_DUR, 32'd0);
                    write_register(scr_pkg::REG_INACT_DUR, 32'd0);
                    write_register(scr_pkg::REG_UPTAKE, 32'hFFFF);
                end
                2: begin
                    write_register(scr_pkg::REG_OPEN_DUR, 32'h7FFF);
                    write_register(scr_pkg::REG_INACT_DUR, 32'h7FFF);
                    write_register(scr_pkg::REG_UPTAKE, 32'd0);
                end
                3: begin
                    write_register(scr_pkg::REG_OPEN_DUR, $urandom_range(0, 30));
                    write_register(scr_pkg::REG_INACT_DUR, $urandom_range(0, 60));
                    write_register(scr_pkg::REG_UPTAKE, $urandom_range(0, 3000));
                end
                default: begin
                    write_register(scr_pkg::REG_OPEN_DUR, $urandom);
                    write_register(scr_pkg::REG_INACT_DUR, $urandom);
                    write_register(scr_pkg::REG_UPTAKE, $urandom);
                end
            endcase
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target) run_random_tick();
        end
    endtask

    initial begin : main_sequence
        int j;
        for (j = 0; j < UNIT_COUNT; j++) begin
            unit_state_m[j] = scr_pkg::US_CLOSED;
            unit_stamp_m[j] = '0;
            window_count_m[j] = '0;
        end
        unit_state_m[0] = scr_pkg::US_OPEN;
        unit_stamp_m[0] = 16'(scr_pkg::UNIT0_STAMP);
        tick_count_m = '0;
        cfg_open_dur = scr_pkg::OPEN_DUR_RST;
        cfg_inact_dur = scr_pkg::INACT_DUR_RST;
        cfg_uptake = scr_pkg::UPTAKE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_window_saturation();
        test_random_ticks();
        wait_idle();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
